/* src/next_lexicographic_permutation_top_defines.svh */
// Assertion macros for the next-permutation block.
`ifndef NEXT_LEXICOGRAPHIC_PERMUTATION_TOP_DEFINES_SVH
`define NEXT_LEXICOGRAPHIC_PERMUTATION_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset
`define NLP_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);
// Condition must never be seen outside reset
`define NLP_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);
`else
`define NLP_ASSERT(label, clk, rst_n, prop, msg)
`define NLP_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

/* src/nlp_pkg.sv */
`timescale 1ns / 1ps

package nlp_pkg;

  // Width of the element count register
  localparam int CFG_W = 4;

  // Element count after reset
  localparam logic [CFG_W-1:0] COUNT_RESET = 4'd10;

endpackage

/* src/nlp_ascent.sv */
`timescale 1ns / 1ps

`include "next_lexicographic_permutation_top_defines.svh"

// Stages 1 and 2: mark ascents, then pick the rightmost one.
module nlp_ascent #(
  parameter int MAX_ELEMENTS = 10,
  parameter int ELEMENT_BITS = 4,
  localparam int SEQ_W = MAX_ELEMENTS * ELEMENT_BITS,
  localparam int IDX_W = $clog2(MAX_ELEMENTS),
  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic [SEQ_W-1:0]           seq_i,
  input  logic [nlp_pkg::CFG_W-1:0]  count_i,
  output logic                       valid_o,
  output logic [SEQ_W-1:0]           seq_o,
  output logic [CNT_W-1:0]           n_o,
  output logic [IDX_W-1:0]           k_o,
  output logic                       found_o
);

  import nlp_pkg::*;

  logic [CNT_W-1:0]        n_sat;
  logic [MAX_ELEMENTS-2:0] asc_d;

  logic                    s1_valid_q;
  logic [SEQ_W-1:0]        s1_seq_q;
  logic [CNT_W-1:0]        s1_n_q;
  logic [MAX_ELEMENTS-2:0] s1_asc_q;

  logic [IDX_W-1:0]        k_d;
  logic                    found_d;

  logic                    s2_valid_q;
  logic [SEQ_W-1:0]        s2_seq_q;
  logic [CNT_W-1:0]        s2_n_q;
  logic [IDX_W-1:0]        s2_k_q;
  logic                    s2_found_q;

  // Saturate the count and flag each ascent inside the used slots
  always_comb begin
    if (int'(count_i) > MAX_ELEMENTS) begin
      n_sat = CNT_W'(MAX_ELEMENTS);
    end else begin
      n_sat = CNT_W'(count_i);
    end
    for (int i = 0; i < MAX_ELEMENTS - 1; i++) begin
      asc_d[i] = (int'(n_sat) > i + 1) &&
                 (seq_i[i*ELEMENT_BITS +: ELEMENT_BITS] <
                  seq_i[(i+1)*ELEMENT_BITS +: ELEMENT_BITS]);
    end
  end

  // Stage 1 control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= valid_i;
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk_i) begin
    s1_seq_q <= seq_i;
    s1_n_q   <= n_sat;
    s1_asc_q <= asc_d;
  end

  // Take the rightmost ascent
  always_comb begin
    k_d     = '0;
    found_d = 1'b0;
    for (int i = 0; i < MAX_ELEMENTS - 1; i++) begin
      if (s1_asc_q[i]) begin
        k_d     = IDX_W'(i);
        found_d = 1'b1;
      end
    end
  end

  // Stage 2 control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  // Stage 2 payload
  always_ff @(posedge clk_i) begin
    s2_seq_q   <= s1_seq_q;
    s2_n_q     <= s1_n_q;
    s2_k_q     <= k_d;
    s2_found_q <= found_d;
  end

  assign valid_o = s2_valid_q;
  assign seq_o   = s2_seq_q;
  assign n_o     = s2_n_q;
  assign k_o     = s2_k_q;
  assign found_o = s2_found_q;

  `NLP_ASSERT(a_ascent_in_range, clk_i, rst_ni, (s2_valid_q && s2_found_q) |-> (int'(s2_k_q) + 1 < int'(s2_n_q)), "ascent index outside the used slots")

endmodule

/* src/nlp_pivot.sv */
`timescale 1ns / 1ps

`include "next_lexicographic_permutation_top_defines.svh"

// Stages 3 and 4: find the rightmost tail element above the ascent element.
module nlp_pivot #(
  parameter int MAX_ELEMENTS = 10,
  parameter int ELEMENT_BITS = 4,
  localparam int SEQ_W = MAX_ELEMENTS * ELEMENT_BITS,
  localparam int IDX_W = $clog2(MAX_ELEMENTS),
  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [SEQ_W-1:0] seq_i,
  input  logic [CNT_W-1:0] n_i,
  input  logic [IDX_W-1:0] k_i,
  input  logic             found_i,
  output logic             valid_o,
  output logic [SEQ_W-1:0] seq_o,
  output logic [CNT_W-1:0] n_o,
  output logic [IDX_W-1:0] k_o,
  output logic [IDX_W-1:0] l_o,
  output logic             found_o
);

  import nlp_pkg::*;

  logic [ELEMENT_BITS-1:0] elem [MAX_ELEMENTS];
  logic [ELEMENT_BITS-1:0] ek;
  logic [MAX_ELEMENTS-1:0] gt_d;

  logic                    s3_valid_q;
  logic [SEQ_W-1:0]        s3_seq_q;
  logic [CNT_W-1:0]        s3_n_q;
  logic [IDX_W-1:0]        s3_k_q;
  logic                    s3_found_q;
  logic [MAX_ELEMENTS-1:0] s3_gt_q;

  logic [IDX_W-1:0]        l_d;

  logic                    s4_valid_q;
  logic [SEQ_W-1:0]        s4_seq_q;
  logic [CNT_W-1:0]        s4_n_q;
  logic [IDX_W-1:0]        s4_k_q;
  logic [IDX_W-1:0]        s4_l_q;
  logic                    s4_found_q;

  // Compare each tail element against element k
  always_comb begin
    for (int i = 0; i < MAX_ELEMENTS; i++) begin
      elem[i] = seq_i[i*ELEMENT_BITS +: ELEMENT_BITS];
    end
    ek = elem[k_i];
    for (int i = 0; i < MAX_ELEMENTS; i++) begin
      gt_d[i] = (i > int'(k_i)) && (i < int'(n_i)) && (elem[i] > ek);
    end
  end

  // Stage 3 control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= valid_i;
    end
  end

  // Stage 3 payload
  always_ff @(posedge clk_i) begin
    s3_seq_q   <= seq_i;
    s3_n_q     <= n_i;
    s3_k_q     <= k_i;
    s3_found_q <= found_i;
    s3_gt_q    <= gt_d;
  end

  // Take the rightmost greater element, default to the slot after k
  always_comb begin
    l_d = s3_k_q + IDX_W'(1);
    for (int i = 0; i < MAX_ELEMENTS; i++) begin
      if (s3_gt_q[i]) begin
        l_d = IDX_W'(i);
      end
    end
  end

  // Stage 4 control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
    end else begin
      s4_valid_q <= s3_valid_q;
    end
  end

  // Stage 4 payload
  always_ff @(posedge clk_i) begin
    s4_seq_q   <= s3_seq_q;
    s4_n_q     <= s3_n_q;
    s4_k_q     <= s3_k_q;
    s4_l_q     <= l_d;
    s4_found_q <= s3_found_q;
  end

  assign valid_o = s4_valid_q;
  assign seq_o   = s4_seq_q;
  assign n_o     = s4_n_q;
  assign k_o     = s4_k_q;
  assign l_o     = s4_l_q;
  assign found_o = s4_found_q;

  `NLP_ASSERT_NEVER(a_pivot_exists, clk_i, rst_ni, s3_valid_q && s3_found_q && (s3_gt_q == '0), "ascent found but no greater tail element")

endmodule

/* src/nlp_rearr.sv */
`timescale 1ns / 1ps

// Stage 5: swap pivot with the ascent element and reverse the tail.
module nlp_rearr #(
  parameter int MAX_ELEMENTS = 10,
  parameter int ELEMENT_BITS = 4,
  localparam int SEQ_W = MAX_ELEMENTS * ELEMENT_BITS,
  localparam int IDX_W = $clog2(MAX_ELEMENTS),
  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [SEQ_W-1:0] seq_i,
  input  logic [CNT_W-1:0] n_i,
  input  logic [IDX_W-1:0] k_i,
  input  logic [IDX_W-1:0] l_i,
  input  logic             found_i,
  output logic             valid_o,
  output logic [SEQ_W-1:0] seq_o,
  output logic             wrapped_o
);

  import nlp_pkg::*;

  logic [ELEMENT_BITS-1:0] elem [MAX_ELEMENTS];
  logic [CNT_W:0]          base;
  logic [CNT_W:0]          src;
  logic [IDX_W-1:0]        src_idx;
  logic [SEQ_W-1:0]        seq_d;

  logic                    valid_q;
  logic [SEQ_W-1:0]        seq_q;
  logic                    wrapped_q;

  // Each used slot at or past the reversal base reads its mirror;
  // the ascent slot takes the pivot, and the pivot's mirror takes element k
  always_comb begin
    for (int i = 0; i < MAX_ELEMENTS; i++) begin
      elem[i] = seq_i[i*ELEMENT_BITS +: ELEMENT_BITS];
    end
    base    = found_i ? ((CNT_W+1)'(k_i) + (CNT_W+1)'(1)) : '0;
    seq_d   = seq_i;
    src     = '0;
    src_idx = '0;
    for (int j = 0; j < MAX_ELEMENTS; j++) begin
      src     = (CNT_W+1)'(n_i) - (CNT_W+1)'(1) + base - (CNT_W+1)'(j);
      src_idx = src[IDX_W-1:0];
      if ((j < int'(n_i)) && (j >= int'(base))) begin
        if (found_i && (src_idx == l_i)) begin
          seq_d[j*ELEMENT_BITS +: ELEMENT_BITS] = elem[k_i];
        end else begin
          seq_d[j*ELEMENT_BITS +: ELEMENT_BITS] = elem[src_idx];
        end
      end else if (found_i && (j == int'(k_i))) begin
        seq_d[j*ELEMENT_BITS +: ELEMENT_BITS] = elem[l_i];
      end
    end
  end

  // Result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    seq_q     <= seq_d;
    wrapped_q <= !found_i;
  end

  assign valid_o   = valid_q;
  assign seq_o     = seq_q;
  assign wrapped_o = wrapped_q;

endmodule

/* src/next_lexicographic_permutation_top.sv */
`timescale 1ns / 1ps

`include "next_lexicographic_permutation_top_defines.svh"

// Channel   Handshake                    Payload
// -------   ---------------------------  -----------------------------------
// input     start, busy                  current_sequence_i
// result    result_valid_o (strobe)      next_sequence_o, wrapped_o
// config    cfg_valid_i, cfg_ready_o     cfg_data_i (element count)
//
// Five register stages: ascent flags, ascent pick, pivot compare, pivot pick,
// swap and reverse. One item per cycle; each result shows for one cycle when
// its item leaves the last stage. busy stays low and cfg_ready_o stays high.
// Reset clears every stage valid bit and loads an element count of ten.
// The result side cannot stall, so nothing in the pipeline ever waits.
module next_lexicographic_permutation_top #(
  parameter int MAX_ELEMENTS = 10,
  parameter int ELEMENT_BITS = 4,
  localparam int SEQ_W = MAX_ELEMENTS * ELEMENT_BITS,
  localparam int IDX_W = $clog2(MAX_ELEMENTS),
  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [SEQ_W-1:0]           current_sequence_i,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [nlp_pkg::CFG_W-1:0]  cfg_data_i,
  output logic                       result_valid_o,
  output logic [SEQ_W-1:0]           next_sequence_o,
  output logic                       wrapped_o
);

  import nlp_pkg::*;

  logic [CFG_W-1:0] count_q;

  logic             a_valid;
  logic [SEQ_W-1:0] a_seq;
  logic [CNT_W-1:0] a_n;
  logic [IDX_W-1:0] a_k;
  logic             a_found;

  logic             p_valid;
  logic [SEQ_W-1:0] p_seq;
  logic [CNT_W-1:0] p_n;
  logic [IDX_W-1:0] p_k;
  logic [IDX_W-1:0] p_l;
  logic             p_found;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  // Hold the element count; load it on a config transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= COUNT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      count_q <= cfg_data_i;
    end
  end

  nlp_ascent #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_ascent (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start && !busy),
    .seq_i   (current_sequence_i),
    .count_i (count_q),
    .valid_o (a_valid),
    .seq_o   (a_seq),
    .n_o     (a_n),
    .k_o     (a_k),
    .found_o (a_found)
  );

  nlp_pivot #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_pivot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (a_valid),
    .seq_i   (a_seq),
    .n_i     (a_n),
    .k_i     (a_k),
    .found_i (a_found),
    .valid_o (p_valid),
    .seq_o   (p_seq),
    .n_o     (p_n),
    .k_o     (p_k),
    .l_o     (p_l),
    .found_o (p_found)
  );

  nlp_rearr #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_rearr (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (p_valid),
    .seq_i     (p_seq),
    .n_i       (p_n),
    .k_i       (p_k),
    .l_i       (p_l),
    .found_i   (p_found),
    .valid_o   (result_valid_o),
    .seq_o     (next_sequence_o),
    .wrapped_o (wrapped_o)
  );

  `NLP_ASSERT(a_fixed_latency, clk_i, rst_ni, (start && !busy) |-> ##5 result_valid_o, "result strobe missing five cycles after transfer")

endmodule

/* tb/tb_next_lexicographic_permutation_top.sv */
`timescale 1ns / 1ps

module tb_next_lexicographic_permutation_top;

  localparam int MAX_ELEMENTS = 10;
  localparam int ELEMENT_BITS = 4;
  localparam int SEQ_W = MAX_ELEMENTS * ELEMENT_BITS;
  localparam int ITEMS_PER_PHASE = 135;
  localparam int NO_IDLE_PHASE = 2;
  localparam int DRAIN_CYCLES = 10;
  localparam int CYCLE_LIMIT = 200000;

  typedef logic [nlp_pkg::CFG_W-1:0] count_t;

  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic             wrapped;
  } arrangement_t;

  // Track the element count and the arrangements still owed by the block
  class perm_checker;
    count_t       elem_count = nlp_pkg::COUNT_RESET;
    arrangement_t pending_arrangements[$];
    int           mismatch_count = 0;

    // Compute the next lexicographic arrangement of the used slots
    function arrangement_t next_arrangement(logic [SEQ_W-1:0] seq);
      logic [ELEMENT_BITS-1:0] e[MAX_ELEMENTS];
      logic [ELEMENT_BITS-1:0] t;
      int                      n, k, l, lo, hi, i;
      bit                      found;
      arrangement_t            r;
      n = (elem_count > MAX_ELEMENTS) ? MAX_ELEMENTS : int'(elem_count);
      for (i = 0; i < MAX_ELEMENTS; i++) e[i] = seq[i*ELEMENT_BITS +: ELEMENT_BITS];
      found = 1'b0;
      k = 0;
      // Find the rightmost ascent
      for (i = 0; i + 1 < n; i++) begin
        if (e[i] < e[i+1]) begin
          k = i;
          found = 1'b1;
        end
      end
      if (found) begin
        // Swap the pivot with the rightmost larger element, then reverse the tail
        l = k + 1;
        for (i = k + 1; i < n; i++) if (e[i] > e[k]) l = i;
        t = e[k];
        e[k] = e[l];
        e[l] = t;
        lo = k + 1;
      end else begin
        // Last arrangement: reverse the whole used part back to sorted order
        lo = 0;
      end
      hi = n;
      while (lo + 1 < hi) begin
        t = e[lo];
        e[lo] = e[hi-1];
        e[hi-1] = t;
        lo++;
        hi--;
      end
      for (i = 0; i < MAX_ELEMENTS; i++) r.seq[i*ELEMENT_BITS +: ELEMENT_BITS] = e[i];
      r.wrapped = !found;
      return r;
    endfunction

    function void note_transfer(logic [SEQ_W-1:0] seq);
      pending_arrangements.push_back(next_arrangement(seq));
    endfunction

    function void check_result(logic [SEQ_W-1:0] seq, logic wrapped);
      arrangement_t exp_r;
      if (pending_arrangements.size() == 0) begin
        $error("result with no transfer pending: next_sequence %h wrapped %b", seq, wrapped);
        mismatch_count++;
        return;
      end
      exp_r = pending_arrangements.pop_front();
      if (seq !== exp_r.seq) begin
        $error("next_sequence mismatch: expected %h, actual %h", exp_r.seq, seq);
        mismatch_count++;
      end
      if (wrapped !== exp_r.wrapped) begin
        $error("wrapped mismatch: expected %b, actual %b", exp_r.wrapped, wrapped);
        mismatch_count++;
      end
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic [SEQ_W-1:0] current_sequence_i = '0;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  count_t           cfg_data_i = '0;
  logic             result_valid_o;
  logic [SEQ_W-1:0] next_sequence_o;
  logic             wrapped_o;

  perm_checker      checker_h;
  logic [SEQ_W-1:0] walk_seq = '0;
  int               cycle_count = 0;

  next_lexicographic_permutation_top #(
    .MAX_ELEMENTS(MAX_ELEMENTS),
    .ELEMENT_BITS(ELEMENT_BITS)
  ) u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .current_sequence_i (current_sequence_i),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_data_i         (cfg_data_i),
    .result_valid_o     (result_valid_o),
    .next_sequence_o    (next_sequence_o),
    .wrapped_o          (wrapped_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Check every result strobe
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) checker_h.check_result(next_sequence_o, wrapped_o);
  end

  // Present one sequence, optionally after random idle cycles, and hold until transfer
  task automatic send_seq(input logic [SEQ_W-1:0] seq, input bit may_idle);
    if (may_idle && $urandom_range(99) < 36) begin
      start <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 36);
    end
    start <= 1'b1;
    current_sequence_i <= seq;
    do @(posedge clk_i); while (!(start && !busy));
    checker_h.note_transfer(seq);
  endtask

  // Wait until every owed result has come out, then let the pipeline settle
  task automatic drain;
    while (checker_h.pending_arrangements.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write the element count register
  task automatic write_count(input count_t value);
    while ($urandom_range(99) < 36) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    checker_h.elem_count = value;
    cfg_valid_i <= 1'b0;
  endtask

  // Build a random sequence: permutation walks, few-valued, raw, or sorted either way
  function automatic logic [SEQ_W-1:0] pick_seq();
    int               sel, base, span, i;
    int               e[MAX_ELEMENTS];
    logic [SEQ_W-1:0] s;
    sel = $urandom_range(99);
    base = $urandom_range(12);
    span = $urandom_range(1, 3);
    for (i = 0; i < MAX_ELEMENTS; i++) e[i] = base + $urandom_range(span);
    if (sel < 30) begin
      // Advance the walk, restarting it now and then
      if ($urandom_range(99) < 5) begin
        for (i = 0; i < MAX_ELEMENTS; i++) begin
          walk_seq[i*ELEMENT_BITS +: ELEMENT_BITS] = ELEMENT_BITS'(e[i]);
        end
      end else begin
        walk_seq = checker_h.next_arrangement(walk_seq).seq;
      end
      return walk_seq;
    end
    if (sel < 55) begin
      // Keep the few-valued elements as they are
    end else if (sel < 75) begin
      s = SEQ_W'({$urandom, $urandom});
      return s;
    end else if (sel < 85) begin
      for (i = 0; i < MAX_ELEMENTS; i++) e[i] = $urandom_range(15);
      e.rsort();
    end else begin
      for (i = 0; i < MAX_ELEMENTS; i++) e[i] = $urandom_range(15);
      e.sort();
    end
    for (i = 0; i < MAX_ELEMENTS; i++) s[i*ELEMENT_BITS +: ELEMENT_BITS] = ELEMENT_BITS'(e[i]);
    return s;
  endfunction

  logic [SEQ_W-1:0] directed_seqs[] = '{
    40'h9876543210, 40'h0123456789, 40'h0000000000, 40'hFFFFFFFFFF,
    40'h8976543210, 40'h0123456798, 40'h1100000000, 40'h5555555550,
    40'h0F0F0F0F0F, 40'hF0F0F0F0F0, 40'hAAAAAAAAAA, 40'h5555555555,
    40'h3322110000, 40'h0011223344, 40'h1234567890, 40'hFEDCBA9876,
    40'h0000000001, 40'h1000000000, 40'h2121212121, 40'h6789ABCDEF
  };

  count_t phase_counts[] = '{
    4'd10, 4'd2, 4'd15, 4'd0, 4'd1, 4'd11, 4'd5, 4'd3, 4'd9, 4'd4, 4'd12, 4'd7, 4'd10
  };

  initial begin
    checker_h = new;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed sequences at the reset count of ten
    foreach (directed_seqs[i]) send_seq(directed_seqs[i], 1'b1);
    start <= 1'b0;

    // Random phases, each under its own element count
    foreach (phase_counts[p]) begin
      drain();
      write_count(phase_counts[p]);
      for (int j = 0; j < MAX_ELEMENTS; j++) begin
        walk_seq[j*ELEMENT_BITS +: ELEMENT_BITS] = ELEMENT_BITS'($urandom_range(3));
      end
      for (int j = 0; j < ITEMS_PER_PHASE; j++) send_seq(pick_seq(), p != NO_IDLE_PHASE);
      start <= 1'b0;
    end

    drain();
    if (checker_h.mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
